// ===== src/gfn_pkg.sv =====
// Package for the greedy farthest-neighbor tour block.
// Holds the cell record type, field widths and the state encodings used by the modules.
package gfn_pkg;

   localparam int COORD_W = 16;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int SQ_W    = 34;
   localparam int ROOT_W  = 17;
   localparam int ROOT_STEPS = 17;

   // One city as held by a ring cell
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [IDX_W-1:0]   idx;
      logic               visited;
   } cell_type;

   // Control from the sequencer to every cell
   typedef struct packed {
      logic             rotate;
      logic             start;
      logic             mark;
      logic [IDX_W-1:0] mark_idx;
   } cell_ctrl_type;

   // Handshake with the distance unit
   typedef struct packed {
      logic               done;
      logic [ROOT_W-1:0]  root;
   } dist_res_type;

   typedef enum logic [5:0] {
      S_LOAD  = 6'b000001,
      S_START = 6'b000010,
      S_EMIT  = 6'b000100,
      S_HEAD  = 6'b001000,
      S_DIST  = 6'b010000,
      S_SPARE = 6'b100000
   } seq_state_type;

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_SQX  = 4'b0010,
      D_SQY  = 4'b0100,
      D_ROOT = 4'b1000
   } dist_state_type;

endpackage

// ===== src/gfn_if.sv =====
// Request and result channel interfaces for the greedy farthest-neighbor tour block.
// Depends on gfn_pkg for field widths.
interface gfn_req_if;
   logic                       valid;
   logic                       ready;
   logic [gfn_pkg::COORD_W-1:0] x_coord;
   logic [gfn_pkg::COORD_W-1:0] y_coord;
   logic                       is_last;
   modport source (output valid, output x_coord, output y_coord, output is_last, input ready);
   modport sink   (input valid, input x_coord, input y_coord, input is_last, output ready);
endinterface

interface gfn_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [gfn_pkg::IDX_W-1:0] city_index;
   logic                      tour_end;
   modport source (output valid, output city_index, output tour_end, input ready);
   modport sink   (input valid, input city_index, input tour_end, output ready);
endinterface

// ===== src/greedy_farthest_neighbor_tour.sv =====
// Greedy farthest-neighbor tour top level: city ring, distance unit and step sequencer.
// Depends on gfn_pkg, gfn_if, gfn_cell and gfn_dist.
//
// Load cities one request per cycle, flagging the final one with is_last; cities beyond
// MAX_CITIES are dropped. The tour then starts at city 0 and repeatedly moves to the
// farthest unvisited city, lowest index on ties. The cities sit in a ring of MAX_CITIES
// cells that rotates one place per scanned slot; each unvisited candidate also passes
// through the shared distance unit (squaring dx and dy, 17 root steps, one compare).
// No new request is accepted until the last result of a tour has been placed in the
// output register.
module greedy_farthest_neighbor_tour #(
   parameter int MAX_CITIES = 64
) (
   input  logic          clock,
   input  logic          reset,
   gfn_req_if.sink       req_if,
   gfn_rsp_if.source     rsp_if
);

   localparam int SCAN_W = $clog2(MAX_CITIES + 1);

   gfn_pkg::seq_state_type state_ff, state_in;
   logic [gfn_pkg::CNT_W-1:0]   count_ff, count_in, pos_ff, pos_in;
   logic [SCAN_W-1:0]           scan_ff, scan_in;
   logic                        found_ff, found_in;
   logic [gfn_pkg::ROOT_W-1:0]  best_ff, best_in;
   logic [gfn_pkg::IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [gfn_pkg::COORD_W-1:0] best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [gfn_pkg::COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gfn_pkg::IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic                        rsp_end_ff, rsp_end_in;

   gfn_pkg::cell_ctrl_type ctrl;
   gfn_pkg::cell_type      cells [MAX_CITIES];
   gfn_pkg::cell_type      head;
   gfn_pkg::dist_res_type  dres;
   logic                   dist_start;
   logic                   req_take, store_ok, head_skip, out_free;

   assign head     = cells[0];
   assign req_take = req_if.valid && req_if.ready;
   assign store_ok = (count_ff < gfn_pkg::CNT_W'(MAX_CITIES));
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign head_skip = head.visited || ({1'b0, head.idx} >= count_ff);

   // Ring of cells, each shifting toward the head
   for (genvar i = 0; i < MAX_CITIES; i++) begin : g_cell
      gfn_cell #(.POS(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load_en   (req_take && (count_ff == gfn_pkg::CNT_W'(i))),
         .load_x    (req_if.x_coord),
         .load_y    (req_if.y_coord),
         .next_cell (cells[(i + 1) % MAX_CITIES]),
         .cell_out  (cells[i])
      );
   end

   gfn_dist u_dist (
      .clock (clock),
      .reset (reset),
      .start (dist_start),
      .ax    (cur_x_ff),
      .ay    (cur_y_ff),
      .bx    (head.x),
      .by    (head.y),
      .res   (dres)
   );

   // Sequence loading, scanning and emitting
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_end_in   = rsp_end_ff;
      ctrl         = '0;
      dist_start   = 1'b0;
      case (state_ff)
         gfn_pkg::S_LOAD: begin
            if (req_take) begin
               if (store_ok) begin
                  count_in = count_ff + gfn_pkg::CNT_W'(1);
               end
               if (req_if.is_last) begin
                  state_in = gfn_pkg::S_START;
               end
            end
         end
         gfn_pkg::S_START: begin
            ctrl.start  = 1'b1;
            best_idx_in = '0;
            best_x_in   = head.x;
            best_y_in   = head.y;
            pos_in      = '0;
            state_in    = gfn_pkg::S_EMIT;
         end
         gfn_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = best_idx_ff;
               rsp_end_in    = (pos_ff + gfn_pkg::CNT_W'(1) == count_ff);
               ctrl.mark     = 1'b1;
               ctrl.mark_idx = best_idx_ff;
               cur_x_in      = best_x_ff;
               cur_y_in      = best_y_ff;
               pos_in        = pos_ff + gfn_pkg::CNT_W'(1);
               scan_in       = '0;
               found_in      = 1'b0;
               if (pos_ff + gfn_pkg::CNT_W'(1) == count_ff) begin
                  count_in = '0;
                  state_in = gfn_pkg::S_LOAD;
               end else begin
                  state_in = gfn_pkg::S_HEAD;
               end
            end
         end
         gfn_pkg::S_HEAD: begin
            if (head_skip) begin
               ctrl.rotate = 1'b1;
               scan_in     = scan_ff + SCAN_W'(1);
               if (scan_ff == SCAN_W'(MAX_CITIES - 1)) begin
                  state_in = gfn_pkg::S_EMIT;
               end
            end else begin
               dist_start = 1'b1;
               state_in   = gfn_pkg::S_DIST;
            end
         end
         gfn_pkg::S_DIST: begin
            if (dres.done) begin
               if (!found_ff || (dres.root > best_ff)) begin
                  found_in    = 1'b1;
                  best_in     = dres.root;
                  best_idx_in = head.idx;
                  best_x_in   = head.x;
                  best_y_in   = head.y;
               end
               ctrl.rotate = 1'b1;
               scan_in     = scan_ff + SCAN_W'(1);
               if (scan_ff == SCAN_W'(MAX_CITIES - 1)) begin
                  state_in = gfn_pkg::S_EMIT;
               end else begin
                  state_in = gfn_pkg::S_HEAD;
               end
            end
         end
         default: state_in = gfn_pkg::S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gfn_pkg::S_LOAD;
         count_ff     <= '0;
         pos_ff       <= '0;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         scan_ff      <= scan_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign req_if.ready      = (state_ff == gfn_pkg::S_LOAD);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.city_index = rsp_idx_ff;
   assign rsp_if.tour_end   = rsp_end_ff;

endmodule

// ===== src/gfn_cell.sv =====
// One cell of the rotating city ring: holds coordinates, index and visited flag.
// Depends on gfn_pkg for the cell record and control types.
module gfn_cell #(
   parameter int POS = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gfn_pkg::cell_ctrl_type      ctrl,
   input  logic                        load_en,
   input  logic [gfn_pkg::COORD_W-1:0] load_x,
   input  logic [gfn_pkg::COORD_W-1:0] load_y,
   input  gfn_pkg::cell_type           next_cell,
   output gfn_pkg::cell_type           cell_out
);

   gfn_pkg::cell_type cell_ff, cell_in;

   // Pick the next content: shift from neighbor, load, or update flags
   always_comb begin
      cell_in = cell_ff;
      if (ctrl.rotate) begin
         cell_in = next_cell;
      end else if (load_en) begin
         cell_in.x       = load_x;
         cell_in.y       = load_y;
         cell_in.visited = 1'b0;
      end else if (ctrl.start) begin
         cell_in.visited = (cell_ff.idx == '0);
      end else if (ctrl.mark && (cell_ff.idx == ctrl.mark_idx)) begin
         cell_in.visited = 1'b1;
      end
   end

   // Index is control state; coordinates need no reset
   always_ff @(posedge clock) begin
      cell_ff.x       <= cell_in.x;
      cell_ff.y       <= cell_in.y;
      cell_ff.visited <= cell_in.visited;
      if (reset) begin
         cell_ff.idx <= gfn_pkg::IDX_W'(POS);
      end else begin
         cell_ff.idx <= cell_in.idx;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ===== src/gfn_dist.sv =====
// Distance unit: squares dx and then dy, then a 17-step integer square root.
// Depends on gfn_pkg for widths and the state encoding.
module gfn_dist (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gfn_pkg::COORD_W-1:0] ax,
   input  logic [gfn_pkg::COORD_W-1:0] ay,
   input  logic [gfn_pkg::COORD_W-1:0] bx,
   input  logic [gfn_pkg::COORD_W-1:0] by,
   output gfn_pkg::dist_res_type       res
);

   gfn_pkg::dist_state_type state_ff, state_in;
   logic [gfn_pkg::COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [gfn_pkg::SQ_W-1:0]    v_ff, v_in, root_ff, root_in, bit_ff, bit_in;
   logic [4:0]                  step_ff, step_in;
   logic                        done_ff, done_in;
   logic [gfn_pkg::SQ_W-1:0]    trial;
   logic [2*gfn_pkg::COORD_W-1:0] sq;

   assign trial = root_ff + bit_ff;
   assign sq    = (state_ff == gfn_pkg::D_SQX) ? dx_ff * dx_ff : dy_ff * dy_ff;

   // Advance squaring and root iterations
   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      v_in     = v_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      case (state_ff)
         gfn_pkg::D_IDLE: begin
            if (start) begin
               dx_in    = (ax > bx) ? ax - bx : bx - ax;
               dy_in    = (ay > by) ? ay - by : by - ay;
               state_in = gfn_pkg::D_SQX;
            end
         end
         gfn_pkg::D_SQX: begin
            v_in     = gfn_pkg::SQ_W'(sq);
            state_in = gfn_pkg::D_SQY;
         end
         gfn_pkg::D_SQY: begin
            v_in     = v_ff + gfn_pkg::SQ_W'(sq);
            root_in  = '0;
            bit_in   = gfn_pkg::SQ_W'(1) << (2 * (gfn_pkg::ROOT_STEPS - 1));
            step_in  = '0;
            state_in = gfn_pkg::D_ROOT;
         end
         gfn_pkg::D_ROOT: begin
            if (v_ff >= trial) begin
               v_in    = v_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(gfn_pkg::ROOT_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = gfn_pkg::D_IDLE;
            end
         end
         default: state_in = gfn_pkg::D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gfn_pkg::D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      v_ff    <= v_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
   end

   assign res.done = done_ff;
   assign res.root = root_ff[gfn_pkg::ROOT_W-1:0];

endmodule

// ===== tb/gfn_tour_checker.sv =====
// Checker for the greedy farthest-neighbor tour block: watches both channels,
// builds the expected tour for each city set and compares each result.
// Depends on gfn_pkg and gfn_if.
`timescale 1ns / 100ps

module gfn_tour_checker #(
   parameter int MAX_CITIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   gfn_req_if.sink          req_mon,
   gfn_rsp_if.sink          rsp_mon,
   output int               fail_count,
   output int               tour_pending
);

   typedef struct packed {
      logic [gfn_pkg::IDX_W-1:0] city_index;
      logic                      tour_end;
   } tour_stop_type;

   logic [gfn_pkg::COORD_W-1:0] x_held [MAX_CITIES];
   logic [gfn_pkg::COORD_W-1:0] y_held [MAX_CITIES];
   int                          cities_held;
   tour_stop_type               tour_q[$];

   // Floor square root, one result bit per step
   function automatic logic [gfn_pkg::ROOT_W-1:0] floor_root(logic [gfn_pkg::SQ_W-1:0] v);
      logic [35:0] rem;
      logic [35:0] root;
      logic [35:0] bitv;
      rem  = 36'(v);
      root = '0;
      bitv = 36'd1 << 34;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[gfn_pkg::ROOT_W-1:0];
   endfunction

   function automatic logic [gfn_pkg::ROOT_W:0] city_gap(int a, int b);
      logic [gfn_pkg::COORD_W-1:0] dx;
      logic [gfn_pkg::COORD_W-1:0] dy;
      logic [gfn_pkg::SQ_W-1:0]    sq;
      dx = (x_held[a] > x_held[b]) ? x_held[a] - x_held[b] : x_held[b] - x_held[a];
      dy = (y_held[a] > y_held[b]) ? y_held[a] - y_held[b] : y_held[b] - y_held[a];
      sq = gfn_pkg::SQ_W'(dx) * gfn_pkg::SQ_W'(dx) + gfn_pkg::SQ_W'(dy) * gfn_pkg::SQ_W'(dy);
      return {1'b0, floor_root(sq)} + 1'b1;
   endfunction

   // Build the whole greedy tour over the stored cities
   task automatic build_tour();
      logic [MAX_CITIES-1:0]     seen;
      logic [gfn_pkg::ROOT_W:0]  best;
      logic [gfn_pkg::ROOT_W:0]  d;
      int                        here;
      int                        pick;
      bit                        found;
      tour_stop_type             s;
      seen = '0;
      seen[0] = 1'b1;
      here = 0;
      s.city_index = '0;
      s.tour_end = (cities_held <= 1);
      tour_q.push_back(s);
      for (int pos = 1; pos < cities_held; pos++) begin
         found = 0;
         best = '0;
         pick = 0;
         for (int j = 0; j < cities_held; j++) begin
            if (!seen[j]) begin
               d = city_gap(here, j);
               if (!found || d > best) begin
                  best = d;
                  pick = j;
                  found = 1;
               end
            end
         end
         seen[pick] = 1'b1;
         here = pick;
         s.city_index = gfn_pkg::IDX_W'(pick);
         s.tour_end = (pos + 1 == cities_held);
         tour_q.push_back(s);
      end
   endtask

   // Store cities, predict on is_last, compare each result
   always @(posedge clock) begin
      tour_stop_type want;
      int            errs;
      errs = 0;
      if (reset) begin
         cities_held = 0;
         tour_q.delete();
         fail_count   <= 0;
         tour_pending <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (tour_q.size() == 0) begin
               $error("unexpected result city_index=%0d", rsp_mon.city_index);
               errs = errs + 1;
            end else begin
               want = tour_q.pop_front();
               if (rsp_mon.city_index !== want.city_index) begin
                  $error("city_index: expected %0d, got %0d",
                         want.city_index, rsp_mon.city_index);
                  errs = errs + 1;
               end
               if (rsp_mon.tour_end !== want.tour_end) begin
                  $error("tour_end: expected %0d, got %0d", want.tour_end, rsp_mon.tour_end);
                  errs = errs + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (cities_held < MAX_CITIES) begin
               x_held[cities_held] = req_mon.x_coord;
               y_held[cities_held] = req_mon.y_coord;
               cities_held = cities_held + 1;
            end
            if (req_mon.is_last) begin
               build_tour();
               cities_held = 0;
            end
         end
         fail_count   <= fail_count + errs;
         tour_pending <= tour_q.size();
      end
   end
endmodule

// ===== tb/tb.sv =====
// Top of the greedy farthest-neighbor tour testbench: clock, reset, city set stimulus,
// result stalls and verdict. Depends on gfn_pkg, gfn_if, the block and gfn_tour_checker.
`timescale 1ns / 100ps

module tb;

   localparam int NCITY = 64;
   localparam int IDLE_LIMIT = 200000;

   logic clock;
   logic reset;
   int   fail_count;
   int   tour_pending;
   int   idle_cycles;

   gfn_req_if req_ch ();
   gfn_rsp_if rsp_ch ();

   greedy_farthest_neighbor_tour #(.MAX_CITIES(NCITY)) dut (
      .clock(clock), .reset(reset), .req_if(req_ch.sink), .rsp_if(rsp_ch.source)
   );

   gfn_tour_checker #(.MAX_CITIES(NCITY)) u_checker (
      .clock(clock), .reset(reset), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
      .fail_count(fail_count), .tour_pending(tour_pending)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Send one city request, with a random gap before it
   task automatic send_city(logic [15:0] x, logic [15:0] y, logic last);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.x_coord <= x;
      req_ch.y_coord <= y;
      req_ch.is_last <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [15:0] rand_coord(int mode);
      case (mode)
         0: return 16'($urandom_range(0, 3));
         1: return 16'($urandom_range(65532, 65535));
         2: return 16'($urandom_range(100, 140));
         default: return 16'($urandom);
      endcase
   endfunction

   // Send a set of n cities, last one flagged
   task automatic send_set(int n);
      int mode;
      mode = $urandom_range(0, 5);
      for (int i = 0; i < n; i++)
         send_city(rand_coord(mode), rand_coord(mode), i == n - 1);
   endtask

   // Stall the result side at random
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if ($urandom_range(0, 19) == 0) rsp_ch.ready <= 1'b0;
      else if ($urandom_range(0, 2) != 0) rsp_ch.ready <= 1'b1;
   end

   // Watchdog on cycles without any accepted request or result
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      int n;
      req_ch.valid   = 1'b0;
      req_ch.x_coord = '0;
      req_ch.y_coord = '0;
      req_ch.is_last = 1'b0;
      rsp_ch.ready   = 1'b0;
      reset          = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: single city, coordinate extremes, coincident cities
      send_city(16'hFFFF, 16'h0000, 1'b1);
      send_city(16'h0000, 16'h0000, 1'b0);
      send_city(16'hFFFF, 16'hFFFF, 1'b0);
      send_city(16'hFFFF, 16'h0000, 1'b0);
      send_city(16'h0000, 16'hFFFF, 1'b1);
      for (int i = 0; i < 4; i++) send_city(16'h5A5A, 16'hA5A5, i == 3);
      send_city(16'd0, 16'd0, 1'b0);
      send_city(16'd3, 16'd4, 1'b0);
      send_city(16'd4, 16'd3, 1'b0);
      send_city(16'd5, 16'd0, 1'b1);
      // Overflow: 64 stored, two dropped, last dropped one still ends the set
      for (int i = 0; i < NCITY + 2; i++)
         send_city(rand_coord(3), rand_coord(3), i == NCITY + 1);
      // Random sets, mostly small
      for (int k = 0; k < 11; k++) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
         send_set(n);
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (tour_pending == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule
